[rtl/bfe_pkg.sv]
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types, symbol codes and status codes for the Brainfuck executor.
// ----------------------------------------------------------------------------
package bfe_pkg;

    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_RIGHT = 8'h3E;
    localparam logic [7:0] C_LEFT  = 8'h3C;
    localparam logic [7:0] C_OPEN  = 8'h5B;
    localparam logic [7:0] C_CLOSE = 8'h5D;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_NL    = 8'h0A;
    localparam logic [7:0] C_SPACE = 8'h20;

    typedef enum logic [2:0] {
        ST_LOADED   = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_REJECTED = 3'd2,
        ST_STEPPED  = 3'd3,
        ST_HALTED   = 3'd4,
        ST_TOO_LONG = 3'd5
    } t_status;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_tape_ctl;

    function automatic logic symbol_ok(input logic [7:0] c);
        return c == C_PLUS || c == C_MINUS || c == C_RIGHT || c == C_LEFT ||
               c == C_OPEN || c == C_CLOSE || c == C_COMMA || c == C_DOT ||
               c == C_NL || c == C_SPACE;
    endfunction

endpackage

[rtl/bfe_ram.sv]
// ----------------------------------------------------------------------------
// bfe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bfe_tape.sv]
// ----------------------------------------------------------------------------
// bfe_tape
// Byte tape: RAM plus per-cell valid bits so unwritten cells read as zero.
// ----------------------------------------------------------------------------
module bfe_tape
    import bfe_pkg::*;
#(
    parameter int TAPE_CELLS = 32,
    localparam int TW = $clog2(TAPE_CELLS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_tape_ctl       i_ctl,
    input  logic [TW-1:0]   i_addr,
    input  logic [7:0]      i_wdata,
    output logic [7:0]      o_rdata
);

    logic [TAPE_CELLS-1:0] r_valid;
    logic                  r_rd_valid;
    logic [7:0]            w_q;

    bfe_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr),
        .i_waddr (i_addr),
        .i_wdata (i_wdata),
        .i_raddr (i_addr),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? w_q : 8'd0;

endmodule

[rtl/brainfuck_executor.sv]
// ----------------------------------------------------------------------------
// brainfuck_executor
// Loads, checks and bracket-pairs a Brainfuck program, then steps it on a tape.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                          | tuser  | tlast
//  s_axis   | in        | program_char, input_byte       | mode   | last
//  m_axis   | out       | out_valid, out_byte, input_taken,| status | -
//           |           | cell_value, tape_position      |        |
//
//  Load word: accept, finish and done states; a closing bracket adds a stack
//  read, then two partner RAM writes. Step word: execute (program and partner
//  RAM read) and done, plus a tape read for a pointer move; halted skips to done.
//  Reset clears tape valid bits and the main control state.
//  A result waits in the output register; a stalled m_axis holds the
//  next result in the done state until the register frees.
// ----------------------------------------------------------------------------
module brainfuck_executor
    import bfe_pkg::*;
#(
    parameter int TAPE_CELLS    = 32,
    parameter int PROGRAM_CHARS = 256,
    parameter int NEST_DEPTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // program_char[7:0], input_byte[15:8]
    input  logic [0:0]  i_s_axis_tuser,  // mode[0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_valid[0], out_byte[8:1], input_taken[9], cell_value[17:10],
    // tape_position[22:18], zero[23]
    output logic [23:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser   // status[2:0]
);

    localparam int AW  = $clog2(PROGRAM_CHARS);
    localparam int LW  = AW + 1;
    localparam int TW  = $clog2(TAPE_CELLS);
    localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int DW  = $clog2(NEST_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_POP, S_PAIR, S_LFIN, S_EXEC, S_MOVE, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_lv, n_lv;
    logic          r_ready, n_ready;
    logic [LW-1:0] r_pc, n_pc;
    logic [LW-1:0] r_acc_len, n_acc_len;
    logic [TW-1:0] r_ptr, n_ptr;
    logic [7:0]    r_cell, n_cell;

    logic          r_last, n_last;
    logic          r_toolong, n_toolong;
    logic [7:0]    r_ibyte, n_ibyte;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_open, n_open;

    t_status       r_status, n_status;
    logic          r_outv, n_outv;
    logic [7:0]    r_outb, n_outb;
    logic          r_taken, n_taken;

    logic          r_ovalid, n_ovalid;
    t_status       r_o_status, n_o_status;
    logic          r_o_outv, n_o_outv;
    logic [7:0]    r_o_outb, n_o_outb;
    logic          r_o_taken, n_o_taken;
    logic [7:0]    r_o_cell, n_o_cell;
    logic [4:0]    r_o_pos, n_o_pos;

    logic          prog_we;
    logic [AW-1:0] prog_waddr, prog_raddr;
    logic [7:0]    prog_wdata, prog_q;
    logic          part_we;
    logic [AW-1:0] part_waddr, part_raddr, part_wdata, part_q;
    logic          stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [AW-1:0] stk_wdata, stk_q;
    t_tape_ctl     tape_ctl;
    logic [TW-1:0] tape_addr;
    logic [7:0]    tape_wdata, tape_q;

    logic          w_in_acc;
    logic [7:0]    w_char;
    logic [DW-1:0] w_dm1;
    logic [LW-1:0] w_jump;
    logic [8:0]    w_ptr9;

    assign w_in_acc = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_char   = i_s_axis_tdata[7:0];
    assign w_dm1    = r_depth - DW'(1);
    assign w_jump   = LW'(part_q) + LW'(1);
    assign w_ptr9   = 9'(r_ptr);

    bfe_ram #(.WIDTH(8), .DEPTH(PROGRAM_CHARS)) u_prog (
        .i_clk(i_clk), .i_we(prog_we), .i_waddr(prog_waddr), .i_wdata(prog_wdata),
        .i_raddr(prog_raddr), .o_rdata(prog_q)
    );

    bfe_ram #(.WIDTH(AW), .DEPTH(PROGRAM_CHARS)) u_partner (
        .i_clk(i_clk), .i_we(part_we), .i_waddr(part_waddr), .i_wdata(part_wdata),
        .i_raddr(part_raddr), .o_rdata(part_q)
    );

    bfe_ram #(.WIDTH(AW), .DEPTH(NEST_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_q)
    );

    bfe_tape #(.TAPE_CELLS(TAPE_CELLS)) u_tape (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(tape_ctl), .i_addr(tape_addr),
        .i_wdata(tape_wdata), .o_rdata(tape_q)
    );

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_depth    = r_depth;
        n_lv       = r_lv;
        n_ready    = r_ready;
        n_pc       = r_pc;
        n_acc_len  = r_acc_len;
        n_ptr      = r_ptr;
        n_cell     = r_cell;
        n_last     = r_last;
        n_toolong  = r_toolong;
        n_ibyte    = r_ibyte;
        n_pos      = r_pos;
        n_open     = r_open;
        n_status   = r_status;
        n_outv     = r_outv;
        n_outb     = r_outb;
        n_taken    = r_taken;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_o_status = r_o_status;
        n_o_outv   = r_o_outv;
        n_o_outb   = r_o_outb;
        n_o_taken  = r_o_taken;
        n_o_cell   = r_o_cell;
        n_o_pos    = r_o_pos;

        prog_we    = 1'b0;
        prog_waddr = r_len[AW-1:0];
        prog_wdata = w_char;
        prog_raddr = r_pc[AW-1:0];
        part_we    = 1'b0;
        part_waddr = r_pos;
        part_wdata = stk_q;
        part_raddr = r_pc[AW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_depth[SAW-1:0];
        stk_wdata  = r_len[AW-1:0];
        stk_raddr  = w_dm1[SAW-1:0];
        tape_ctl   = '0;
        tape_addr  = r_ptr;
        tape_wdata = r_cell;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_outv  = 1'b0;
                    n_outb  = 8'd0;
                    n_taken = 1'b0;
                    if (i_s_axis_tuser[0] == 1'b0) begin
                        n_ready = 1'b0;
                        n_last  = i_s_axis_tlast;
                        n_state = S_LFIN;
                        if (r_len >= LW'(PROGRAM_CHARS)) begin
                            n_lv      = 1'b0;
                            n_toolong = 1'b1;
                        end else begin
                            n_toolong = 1'b0;
                            prog_we   = 1'b1;
                            n_len     = r_len + LW'(1);
                            n_pos     = r_len[AW-1:0];
                            if (!symbol_ok(w_char)) begin
                                n_lv = 1'b0;
                            end else if (r_lv && w_char == C_OPEN) begin
                                if (r_depth >= DW'(NEST_DEPTH)) begin
                                    n_lv = 1'b0;
                                end else begin
                                    stk_we  = 1'b1;
                                    n_depth = r_depth + DW'(1);
                                end
                            end else if (r_lv && w_char == C_CLOSE) begin
                                if (r_depth == '0) begin
                                    n_lv = 1'b0;
                                end else begin
                                    n_depth = w_dm1;
                                    n_state = S_POP;
                                end
                            end
                        end
                    end else begin
                        n_ibyte = i_s_axis_tdata[15:8];
                        if (!r_ready || r_pc >= r_acc_len) begin
                            n_status = ST_HALTED;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                end
            end
            S_POP: begin
                n_open  = stk_q;
                part_we = 1'b1;
                n_state = S_PAIR;
            end
            S_PAIR: begin
                part_we    = 1'b1;
                part_waddr = r_open;
                part_wdata = r_pos;
                n_state    = S_LFIN;
            end
            S_LFIN: begin
                n_status = r_toolong ? ST_TOO_LONG : ST_LOADED;
                if (r_last) begin
                    if (!r_toolong) begin
                        if (r_lv && r_depth == '0) begin
                            n_status  = ST_ACCEPTED;
                            n_ready   = 1'b1;
                            n_acc_len = r_len;
                            n_pc      = '0;
                        end else begin
                            n_status = ST_REJECTED;
                        end
                    end
                    n_len   = '0;
                    n_depth = '0;
                    n_lv    = 1'b1;
                end
                n_state = S_DONE;
            end
            S_EXEC: begin
                n_status = ST_STEPPED;
                n_pc     = r_pc + LW'(1);
                n_state  = S_DONE;
                case (prog_q)
                    C_PLUS: begin
                        n_cell      = r_cell + 8'd1;
                        tape_ctl.wr = 1'b1;
                        tape_wdata  = r_cell + 8'd1;
                    end
                    C_MINUS: begin
                        n_cell      = r_cell - 8'd1;
                        tape_ctl.wr = 1'b1;
                        tape_wdata  = r_cell - 8'd1;
                    end
                    C_COMMA: begin
                        n_cell      = r_ibyte;
                        tape_ctl.wr = 1'b1;
                        tape_wdata  = r_ibyte;
                        n_taken     = 1'b1;
                    end
                    C_DOT: begin
                        n_outv = 1'b1;
                        n_outb = r_cell;
                    end
                    C_LEFT: begin
                        if (r_ptr != '0) begin
                            n_ptr = r_ptr - TW'(1);
                        end
                        tape_ctl.rd = 1'b1;
                        tape_addr   = n_ptr;
                        n_state     = S_MOVE;
                    end
                    C_RIGHT: begin
                        if (r_ptr != TW'(TAPE_CELLS - 1)) begin
                            n_ptr = r_ptr + TW'(1);
                        end
                        tape_ctl.rd = 1'b1;
                        tape_addr   = n_ptr;
                        n_state     = S_MOVE;
                    end
                    C_OPEN: begin
                        if (r_cell == 8'd0) begin
                            n_pc = w_jump;
                        end
                    end
                    C_CLOSE: begin
                        if (r_cell != 8'd0) begin
                            n_pc = w_jump;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MOVE: begin
                n_cell  = tape_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_outv   = r_outv;
                    n_o_outb   = r_outb;
                    n_o_taken  = r_taken;
                    n_o_cell   = r_cell;
                    n_o_pos    = w_ptr9[4:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_depth   <= '0;
            r_lv      <= 1'b1;
            r_ready   <= 1'b0;
            r_pc      <= '0;
            r_acc_len <= '0;
            r_ptr     <= '0;
            r_cell    <= 8'd0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_depth   <= n_depth;
            r_lv      <= n_lv;
            r_ready   <= n_ready;
            r_pc      <= n_pc;
            r_acc_len <= n_acc_len;
            r_ptr     <= n_ptr;
            r_cell    <= n_cell;
            r_ovalid  <= n_ovalid;
        end
        r_last     <= n_last;
        r_toolong  <= n_toolong;
        r_ibyte    <= n_ibyte;
        r_pos      <= n_pos;
        r_open     <= n_open;
        r_status   <= n_status;
        r_outv     <= n_outv;
        r_outb     <= n_outb;
        r_taken    <= n_taken;
        r_o_status <= n_o_status;
        r_o_outv   <= n_o_outv;
        r_o_outb   <= n_o_outb;
        r_o_taken  <= n_o_taken;
        r_o_cell   <= n_o_cell;
        r_o_pos    <= n_o_pos;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = {1'b0, r_o_pos, r_o_cell, r_o_taken, r_o_outb, r_o_outv};

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(NEST_DEPTH))
        else $error("nesting depth beyond limit");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(PROGRAM_CHARS))
        else $error("load length beyond program store");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= TW'(TAPE_CELLS - 1))
        else $error("cell pointer beyond tape");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("accepted word did not start processing");

    a_done_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (!r_ovalid || i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("finished result not presented");
`endif

endmodule

[dv/brainfuck_executor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_executor_test
// Self-checking bench: a queue-fed driver loads and steps programs, a
// word-level predictor computes each expected result word, and a monitor
// compares them field by field under random idle and stall patterns.
// ----------------------------------------------------------------------------
module brainfuck_executor_test;
    import bfe_pkg::*;

    localparam int   TAPE_CELLS      = 32;
    localparam int   PROGRAM_CHARS   = 256;
    localparam int   NEST_DEPTH      = 16;
    localparam logic MODE_LOAD       = 1'b0;
    localparam logic MODE_STEP       = 1'b1;
    localparam int   WORDS_PER_PHASE = 30;
    localparam int   SETTLE_CYCLES   = 20;
    localparam int   QUIET_LIMIT     = 4000;
    localparam int   KIND_NEST_FULL  = 85;
    localparam int   KIND_NEST_OVER  = 86;

    typedef struct packed {
        logic       drain;
        logic       mode;
        logic [7:0] pchar;
        logic       last;
        logic [7:0] ibyte;
    } t_word;

    typedef struct packed {
        t_status    status;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       input_taken;
        logic [7:0] cell_value;
        logic [4:0] tape_position;
    } t_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    logic [7:0] prog_mem [PROGRAM_CHARS];
    logic [7:0] partner [PROGRAM_CHARS];
    logic [7:0] open_stack [NEST_DEPTH];
    logic [7:0] tape [TAPE_CELLS] = '{default: 8'h00};
    logic [4:0] depth      = '0;
    logic [8:0] load_len   = '0;
    logic       load_ok    = 1'b1;
    logic       prog_ready = 1'b0;
    logic [8:0] prog_len   = '0;
    logic [8:0] pc         = '0;
    logic [4:0] ptr        = '0;

    t_word      word_q [$];
    t_result    result_due_q [$];
    t_word      cur_word = '0;

    int n_sent = 0;
    int n_recv = 0;
    int n_queued = 0;
    int err_count = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 12;
    int recv_stall_pct = 75;
    int n_accepted = 0, n_rejected = 0, n_too_long = 0;
    int n_stepped = 0, n_halted = 0, n_out = 0, n_taken = 0, n_at_end = 0;

    brainfuck_executor #(
        .TAPE_CELLS    (TAPE_CELLS),
        .PROGRAM_CHARS (PROGRAM_CHARS),
        .NEST_DEPTH    (NEST_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_bf_symbol(logic [7:0] c);
        return c inside {C_PLUS, C_MINUS, C_RIGHT, C_LEFT, C_OPEN, C_CLOSE,
                         C_COMMA, C_DOT, C_NL, C_SPACE};
    endfunction

    function automatic t_result execute_word(t_word w);
        t_result r;
        logic [8:0] next_pc;
        logic [7:0] op;
        logic [7:0] open_pos;
        r = '0;
        r.status = ST_LOADED;
        if (w.mode == MODE_LOAD) begin
            prog_ready = 1'b0;
            if (load_len >= PROGRAM_CHARS) begin
                load_ok  = 1'b0;
                r.status = ST_TOO_LONG;
            end else begin
                prog_mem[load_len[7:0]] = w.pchar;
                if (!is_bf_symbol(w.pchar)) begin
                    load_ok = 1'b0;
                end else if (load_ok && w.pchar == C_OPEN) begin
                    if (depth >= NEST_DEPTH) begin
                        load_ok = 1'b0;
                    end else begin
                        open_stack[depth[3:0]] = load_len[7:0];
                        depth = depth + 5'd1;
                    end
                end else if (load_ok && w.pchar == C_CLOSE) begin
                    if (depth == 0) begin
                        load_ok = 1'b0;
                    end else begin
                        depth = depth - 5'd1;
                        open_pos = open_stack[depth[3:0]];
                        partner[load_len[7:0]] = open_pos;
                        partner[open_pos] = load_len[7:0];
                    end
                end
                load_len = load_len + 9'd1;
            end
            if (w.last) begin
                if (r.status != ST_TOO_LONG) begin
                    if (load_ok && depth == 0) begin
                        r.status   = ST_ACCEPTED;
                        prog_ready = 1'b1;
                        prog_len   = load_len;
                        pc         = '0;
                    end else begin
                        r.status = ST_REJECTED;
                    end
                end
                load_len = '0;
                depth    = '0;
                load_ok  = 1'b1;
            end
        end else if (!prog_ready || pc >= prog_len) begin
            r.status = ST_HALTED;
        end else begin
            r.status = ST_STEPPED;
            op = prog_mem[pc[7:0]];
            next_pc = pc + 9'd1;
            case (op)
                C_PLUS:  tape[ptr] = tape[ptr] + 8'd1;
                C_MINUS: tape[ptr] = tape[ptr] - 8'd1;
                C_LEFT:  if (ptr != 0) ptr = ptr - 5'd1;
                C_RIGHT: if (ptr != TAPE_CELLS - 1) ptr = ptr + 5'd1;
                C_COMMA: begin
                    tape[ptr] = w.ibyte;
                    r.input_taken = 1'b1;
                end
                C_DOT: begin
                    r.out_valid = 1'b1;
                    r.out_byte  = tape[ptr];
                end
                C_OPEN:  if (tape[ptr] == 0) next_pc = {1'b0, partner[pc[7:0]]} + 9'd1;
                C_CLOSE: if (tape[ptr] != 0) next_pc = {1'b0, partner[pc[7:0]]} + 9'd1;
                default: ;
            endcase
            pc = next_pc;
        end
        r.cell_value    = tape[ptr];
        r.tape_position = ptr;
        return r;
    endfunction

    task automatic queue_word(logic mode, logic [7:0] pchar, logic last, logic [7:0] ibyte,
                              logic drain);
        t_word w;
        w.drain = drain;
        w.mode  = mode;
        w.pchar = pchar;
        w.last  = last;
        w.ibyte = ibyte;
        word_q.push_back(w);
        n_queued++;
    endtask

    task automatic queue_program(logic [7:0] code [$], logic drain);
        int i;
        for (i = 0; i < code.size(); i++)
            queue_word(MODE_LOAD, code[i], i == code.size() - 1, 8'($urandom_range(255)),
                       drain && i == 0);
    endtask

    task automatic queue_steps(int n, int ibyte);
        int i;
        for (i = 0; i < n; i++)
            queue_word(MODE_STEP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       ibyte < 0 ? 8'($urandom_range(255)) : 8'(ibyte), 1'b0);
    endtask

    function automatic logic [7:0] random_op();
        int r;
        r = $urandom_range(99);
        if (r < 20) return C_PLUS;
        if (r < 34) return C_MINUS;
        if (r < 50) return C_RIGHT;
        if (r < 62) return C_LEFT;
        if (r < 72) return C_COMMA;
        if (r < 86) return C_DOT;
        if (r < 93) return C_NL;
        return C_SPACE;
    endfunction

    task automatic queue_random_program(int kind_sel, logic drain);
        logic [7:0] code [$];
        logic [7:0] c;
        logic [7:0] dir;
        int kind, len, open_n, i, r, n;
        kind = kind_sel < 0 ? $urandom_range(99) : kind_sel;
        open_n = 0;
        if (kind < 8) begin
            len = $urandom_range(20, 36);
            dir = $urandom_range(1) ? C_RIGHT : C_LEFT;
            for (i = 0; i < len; i++)
                code.push_back($urandom_range(99) < 70 ? dir : random_op());
        end else begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                r = $urandom_range(99);
                if (r < 14 && open_n < 4) begin
                    code.push_back(C_OPEN);
                    open_n++;
                end else if (r < 26 && open_n > 0) begin
                    code.push_back(C_CLOSE);
                    open_n--;
                end else begin
                    code.push_back(random_op());
                end
            end
            for (i = 0; i < open_n; i++)
                code.push_back(C_CLOSE);
        end
        if (kind >= 70 && kind < 78) begin
            do c = 8'($urandom_range(255)); while (is_bf_symbol(c));
            code.insert($urandom_range(code.size()), c);
        end else if (kind >= 78 && kind < 84) begin
            code.push_front(C_CLOSE);
        end else if (kind >= 84 && kind < 90) begin
            n = NEST_DEPTH - 1 + kind % 3;
            code.delete();
            for (i = 0; i < n; i++) code.push_back(C_OPEN);
            code.push_back(C_PLUS);
            for (i = 0; i < n; i++) code.push_back(C_CLOSE);
        end else if (kind >= 90 && kind < 95) begin
            code.push_back(C_OPEN);
        end else if (kind >= 95) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                queue_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                           $urandom_range(3) == 0, 8'($urandom_range(255)), drain && i == 0);
            drain = 1'b0;
        end
        queue_program(code, drain);
        if (kind < 70 || (kind >= 84 && kind < 90))
            queue_steps($urandom_range(code.size(), 2 * code.size() + 3), -1);
        else
            queue_steps($urandom_range(1, 3), -1);
    endtask

    always @(posedge i_clk) begin : drive
        t_word nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_due_q.push_back(execute_word(cur_word));
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                        (!word_q[0].drain || (!s_tvalid && n_sent == n_recv))) begin
                    nxt = word_q.pop_front();
                    cur_word <= nxt;
                    s_tdata  <= {nxt.ibyte, nxt.pchar};
                    s_tuser  <= nxt.mode;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            n_recv <= n_recv + 1;
            if (result_due_q.size() == 0) begin
                $error("result word with none expected: tdata %h tuser %0d", m_tdata, m_tuser);
                err_count++;
            end else begin
                want = result_due_q.pop_front();
                if (m_tuser != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    err_count++;
                end
                if (m_tdata[0] != want.out_valid) begin
                    $error("out_valid: expected %0d, got %0d", want.out_valid, m_tdata[0]);
                    err_count++;
                end
                if (m_tdata[8:1] != want.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", want.out_byte, m_tdata[8:1]);
                    err_count++;
                end
                if (m_tdata[9] != want.input_taken) begin
                    $error("input_taken: expected %0d, got %0d", want.input_taken, m_tdata[9]);
                    err_count++;
                end
                if (m_tdata[17:10] != want.cell_value) begin
                    $error("cell_value: expected %0d, got %0d", want.cell_value,
                           m_tdata[17:10]);
                    err_count++;
                end
                if (m_tdata[22:18] != want.tape_position) begin
                    $error("tape_position: expected %0d, got %0d", want.tape_position,
                           m_tdata[22:18]);
                    err_count++;
                end
                case (want.status)
                    ST_ACCEPTED: n_accepted++;
                    ST_REJECTED: n_rejected++;
                    ST_TOO_LONG: n_too_long++;
                    ST_STEPPED:  n_stepped++;
                    ST_HALTED:   n_halted++;
                    default: ;
                endcase
                if (want.out_valid) n_out++;
                if (want.input_taken) n_taken++;
                if (want.tape_position == TAPE_CELLS - 1) n_at_end++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("no word moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL brainfuck_executor");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] code [$];
        int phase_start;
        int i;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_steps(1, -1);
        code = '{C_CLOSE};
        queue_program(code, 1'b0);
        code = '{8'h00, 8'hFF};
        queue_program(code, 1'b0);
        code = '{C_OPEN};
        queue_program(code, 1'b0);
        code = '{C_LEFT, C_OPEN, C_CLOSE, C_COMMA, C_OPEN, C_MINUS, C_RIGHT, C_PLUS,
                 C_LEFT, C_CLOSE, C_RIGHT, C_DOT};
        queue_program(code, 1'b0);
        queue_steps(12, 1);

        phase_start = n_queued;
        queue_random_program(-1, 1'b1);
        while (n_queued - phase_start < WORDS_PER_PHASE) queue_random_program(-1, 1'b0);
        while (word_q.size() != 0) @(negedge i_clk);

        send_idle_pct  = 75;
        recv_stall_pct = 12;
        phase_start = n_queued;
        queue_random_program(KIND_NEST_FULL, 1'b1);
        while (n_queued - phase_start < WORDS_PER_PHASE) queue_random_program(-1, 1'b0);
        while (word_q.size() != 0) @(negedge i_clk);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        code.delete();
        for (i = 0; i < PROGRAM_CHARS + 2; i++) code.push_back(random_op());
        queue_program(code, 1'b1);
        queue_steps(2, -1);
        phase_start = n_queued;
        queue_random_program(KIND_NEST_OVER, 1'b0);
        while (n_queued - phase_start < WORDS_PER_PHASE) queue_random_program(-1, 1'b0);

        while (word_q.size() != 0 || s_tvalid || n_sent != n_recv) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (result_due_q.size() != 0) begin
            $error("%0d expected result words never arrived", result_due_q.size());
            err_count++;
        end
        $display("Sent %0d words: %0d programs accepted, %0d rejected, %0d over-length loads.",
                 n_sent, n_accepted, n_rejected, n_too_long);
        $display("Executed %0d steps, %0d halted; %0d bytes out, %0d taken in, %0d at tape end.",
                 n_stepped, n_halted, n_out, n_taken, n_at_end);
        if (err_count == 0) begin
            $display("PASS brainfuck_executor");
        end else begin
            $display("FAIL brainfuck_executor");
        end
        $finish;
    end

endmodule

[files.f]
rtl/bfe_pkg.sv
rtl/bfe_ram.sv
rtl/bfe_tape.sv
rtl/brainfuck_executor.sv
dv/brainfuck_executor_test.sv
